@@ rtl/rsl_pkg.sv @@
// rpm shift-light bar: shared types, register indexes and colour constants
// no dependencies; imported by every module of the block but the port checker
`timescale 1ns / 1ps

package rsl_pkg;

    localparam int MAX_LEDS    = 64;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [10:0] FULL_SCALE = 11'd1024;

    // configuration register indexes
    localparam logic [2:0] CFG_LED_COUNT      = 3'd0;
    localparam logic [2:0] CFG_DISPLAY_MODE   = 3'd1;
    localparam logic [2:0] CFG_GREEN_THRESH   = 3'd2;
    localparam logic [2:0] CFG_YELLOW_THRESH  = 3'd3;
    localparam logic [2:0] CFG_RED_THRESH     = 3'd4;
    localparam logic [2:0] CFG_BLINK_THRESH   = 3'd5;
    localparam logic [2:0] CFG_BLINK_INTERVAL = 3'd6;

    // display modes; the fourth code behaves as the bar
    localparam logic [1:0] MODE_SOLID  = 2'd0;
    localparam logic [1:0] MODE_CENTRE = 2'd1;
    localparam logic [1:0] MODE_BAR    = 2'd2;

    // solid-fill scale: 102 + floor(922 * level / 1024)
    localparam logic [10:0] SCALE_FLOOR = 11'd102;
    localparam logic [19:0] SCALE_SPAN  = 20'd922;

    localparam logic [7:0] CH_FULL   = 8'hff;
    localparam logic [7:0] CH_YELLOW = 8'd180;

    typedef struct packed {
        logic [6:0]  led_count;
        logic [1:0]  display_mode;
        logic [10:0] green_thresh;
        logic [10:0] yellow_thresh;
        logic [10:0] red_thresh;
        logic [10:0] blink_thresh;
        logic [15:0] blink_interval;
    } t_cfg;

    // one frame as handed from the front end to the pixel emitter
    typedef struct packed {
        logic [6:0] count;
        logic [6:0] lo;
        logic [6:0] hi;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_frame;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_RANGE,
        FS_SCALE,
        FS_PUSH
    } t_front_state;

endpackage

@@ rtl/rsl_front.sv @@
// rpm shift-light bar front end: takes a level, updates the blink state and
// works out one frame descriptor in its range and scale states; uses rsl_pkg
`timescale 1ns / 1ps

module rsl_front
    import rsl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [10:0] i_rpm_level,
    input  logic [31:0] i_now_ms,
    output logic        o_push_valid,
    input  logic        i_push_ready,
    output t_frame      o_frame
);

    t_front_state r_state, n_state;

    logic        r_blink_on, n_blink_on;
    logic [31:0] r_last_toggle, n_last_toggle;
    logic [10:0] r_lvl, n_lvl;
    logic [6:0]  r_count, n_count;
    logic [1:0]  r_mode, n_mode;
    logic        r_on, n_on;
    logic [7:0]  r_red, n_red, r_green, n_green, r_blue, n_blue;
    logic [10:0] r_scale, n_scale;
    logic [6:0]  r_lit, n_lit;
    t_frame      r_frame, n_frame;

    logic        accept;
    logic [10:0] lvl_sat;
    logic [6:0]  count_sat;
    logic [31:0] elapsed;
    logic [19:0] span_prod;
    logic [17:0] lit_sum;
    logic [7:0]  lit_raw;
    logic [18:0] red_prod, green_prod, blue_prod;
    logic [6:0]  spare;
    logic [6:0]  lo;

    assign o_in_ready   = (r_state == FS_IDLE);
    assign accept       = i_in_valid && o_in_ready;
    assign o_push_valid = (r_state == FS_PUSH);
    assign o_frame      = r_frame;

    assign lvl_sat   = (i_rpm_level > FULL_SCALE) ? FULL_SCALE : i_rpm_level;
    assign count_sat = (i_cfg.led_count == 7'd0) ? 7'd1 :
                       (i_cfg.led_count > 7'(MAX_LEDS)) ? 7'(MAX_LEDS) : i_cfg.led_count;
    assign elapsed   = i_now_ms - r_last_toggle;

    assign span_prod = 20'(r_lvl) * SCALE_SPAN;
    assign lit_sum   = 18'(r_lvl) * 18'(r_count) + 18'd1023;
    assign lit_raw   = lit_sum[17:10];

    assign red_prod   = 19'(r_red) * 19'(r_scale);
    assign green_prod = 19'(r_green) * 19'(r_scale);
    assign blue_prod  = 19'(r_blue) * 19'(r_scale);
    assign spare      = r_count - r_lit;
    assign lo         = (r_mode == MODE_CENTRE) ? {1'b0, spare[6:1]} : 7'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= FS_IDLE;
            r_blink_on    <= 1'b1;
            r_last_toggle <= 32'd0;
        end else begin
            r_state       <= n_state;
            r_blink_on    <= n_blink_on;
            r_last_toggle <= n_last_toggle;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lvl   <= n_lvl;
        r_count <= n_count;
        r_mode  <= n_mode;
        r_on    <= n_on;
        r_red   <= n_red;
        r_green <= n_green;
        r_blue  <= n_blue;
        r_scale <= n_scale;
        r_lit   <= n_lit;
        r_frame <= n_frame;
    end

    always_comb begin
        n_state       = r_state;
        n_blink_on    = r_blink_on;
        n_last_toggle = r_last_toggle;
        n_lvl         = r_lvl;
        n_count       = r_count;
        n_mode        = r_mode;
        n_on          = r_on;
        n_red         = r_red;
        n_green       = r_green;
        n_blue        = r_blue;
        n_scale       = r_scale;
        n_lit         = r_lit;
        n_frame       = r_frame;

        unique case (r_state)
            FS_IDLE: begin
                if (accept) begin
                    n_lvl   = lvl_sat;
                    n_count = count_sat;
                    n_mode  = i_cfg.display_mode;
                    if (lvl_sat >= i_cfg.red_thresh) begin
                        n_red = CH_FULL;   n_green = 8'd0;      n_blue = 8'd0;
                    end else if (lvl_sat >= i_cfg.yellow_thresh) begin
                        n_red = CH_FULL;   n_green = CH_YELLOW; n_blue = 8'd0;
                    end else if (lvl_sat >= i_cfg.green_thresh) begin
                        n_red = 8'd0;      n_green = CH_FULL;   n_blue = 8'd0;
                    end else begin
                        n_red = 8'd0;      n_green = 8'd0;      n_blue = CH_FULL;
                    end
                    if (lvl_sat >= i_cfg.blink_thresh) begin
                        if (elapsed >= {16'd0, i_cfg.blink_interval}) begin
                            n_blink_on    = ~r_blink_on;
                            n_last_toggle = i_now_ms;
                        end
                    end else begin
                        n_blink_on    = 1'b1;
                        n_last_toggle = i_now_ms;
                    end
                    n_on    = n_blink_on;
                    n_state = FS_RANGE;
                end
            end
            FS_RANGE: begin
                n_scale = SCALE_FLOOR + 11'(span_prod[19:10]);
                n_lit   = ({1'b0, r_count} < lit_raw) ? r_count : lit_raw[6:0];
                n_state = FS_SCALE;
            end
            FS_SCALE: begin
                n_frame.count = r_count;
                n_frame.red   = r_red;
                n_frame.green = r_green;
                n_frame.blue  = r_blue;
                if (!r_on) begin
                    n_frame.lo = 7'd0;
                    n_frame.hi = 7'd0;
                end else if (r_mode == MODE_SOLID) begin
                    n_frame.red   = red_prod[17:10];
                    n_frame.green = green_prod[17:10];
                    n_frame.blue  = blue_prod[17:10];
                    n_frame.lo    = 7'd0;
                    n_frame.hi    = r_count;
                end else begin
                    n_frame.lo = lo;
                    n_frame.hi = lo + r_lit;
                end
                n_state = FS_PUSH;
            end
            FS_PUSH: begin
                if (i_push_ready) begin
                    n_state = FS_IDLE;
                end
            end
            default: n_state = FS_IDLE;
        endcase
    end

endmodule

@@ rtl/rsl_queue.sv @@
// rpm shift-light bar frame queue: short fifo of frame descriptors between
// the front end and the pixel emitter; uses rsl_pkg
`timescale 1ns / 1ps

module rsl_queue
    import rsl_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push_valid,
    output logic   o_push_ready,
    input  t_frame i_push_frame,
    output logic   o_pop_valid,
    input  logic   i_pop_ready,
    output t_frame o_pop_frame
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_frame             r_entry [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_fill;
    logic               push, pop;

    assign o_push_ready = (r_fill != CNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_fill != '0);
    assign o_pop_frame  = r_entry[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (pop && !push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_entry[r_wr_ptr] <= i_push_frame;
        end
    end

endmodule

@@ rtl/rsl_back.sv @@
// rpm shift-light bar pixel emitter: walks one frame descriptor and sends
// one colour per led through an output register; uses rsl_pkg
`timescale 1ns / 1ps

module rsl_back
    import rsl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_frame_valid,
    output logic       o_frame_ready,
    input  t_frame     i_frame,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [5:0] o_pixel_index,
    output logic [7:0] o_red_level,
    output logic [7:0] o_green_level,
    output logic [7:0] o_blue_level,
    output logic       o_frame_last
);

    logic       r_active;
    t_frame     r_frame;
    logic [5:0] r_idx;
    logic       r_out_valid;
    logic [5:0] r_pixel_index;
    logic [7:0] r_red, r_green, r_blue;
    logic       r_last;

    logic       advance, lit, last;
    logic [6:0] idx_ext;

    assign o_frame_ready = !r_active;
    assign advance       = r_active && (!r_out_valid || i_out_ready);
    assign idx_ext       = {1'b0, r_idx};
    assign lit           = (idx_ext >= r_frame.lo) && (idx_ext < r_frame.hi);
    assign last          = (idx_ext + 7'd1 == r_frame.count);

    assign o_out_valid   = r_out_valid;
    assign o_pixel_index = r_pixel_index;
    assign o_red_level   = r_red;
    assign o_green_level = r_green;
    assign o_blue_level  = r_blue;
    assign o_frame_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (!r_active && i_frame_valid) begin
                r_active <= 1'b1;
                r_idx    <= '0;
            end else if (advance) begin
                if (last) begin
                    r_active <= 1'b0;
                end
                r_idx <= r_idx + 6'd1;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_active && i_frame_valid) begin
            r_frame <= i_frame;
        end
        if (advance) begin
            r_pixel_index <= r_idx;
            r_red         <= lit ? r_frame.red : 8'd0;
            r_green       <= lit ? r_frame.green : 8'd0;
            r_blue        <= lit ? r_frame.blue : 8'd0;
            r_last        <= last;
        end
    end

endmodule

@@ rtl/rpm_shift_light_bar.sv @@
// rpm shift-light bar top level: configuration registers, front end,
// frame queue and pixel emitter; uses rsl_pkg, rsl_front, rsl_queue, rsl_back
//
// usage: each input transaction carries an rpm level (q10, 1024 = full scale,
// higher values saturate) and a millisecond timestamp. the block answers with
// one output transaction per led in use, pixel index 0 upward, frame_last set
// on the final led. colour comes from three of the thresholds; at or above the
// blink threshold the whole bar goes dark on alternate blink intervals.
// configuration writes (index 0..6, data in the low bits) are taken every
// cycle and must only be issued while the block is idle.
// timing: the front end steps through capture, range and scale products and
// hand-off for each transaction, holding at the hand-off while the queue is
// full, then accepts the next input while the emitter is still busy. the
// emitter loads a frame and then sends one led per cycle while the receiver
// is ready; a frame holds n leds, 1 <= n <= 64.
// reset (synchronous, active low) restores the register defaults, turns the
// blink state on, clears the toggle time and empties the queue.
// a stalled receiver holds the current pixel; the two-entry frame queue then
// fills and input ready drops until it drains.
`timescale 1ns / 1ps

module rpm_shift_light_bar
    import rsl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [10:0] i_rpm_level,
    input  logic [31:0] i_now_ms,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [5:0]  o_pixel_index,
    output logic [7:0]  o_red_level,
    output logic [7:0]  o_green_level,
    output logic [7:0]  o_blue_level,
    output logic        o_frame_last
);

    t_cfg   r_cfg;
    t_frame push_frame, pop_frame;
    logic   push_valid, push_ready, pop_valid, pop_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.led_count      <= 7'd8;
            r_cfg.display_mode   <= MODE_BAR;
            r_cfg.green_thresh   <= 11'd512;
            r_cfg.yellow_thresh  <= 11'd768;
            r_cfg.red_thresh     <= 11'd922;
            r_cfg.blink_thresh   <= 11'd973;
            r_cfg.blink_interval <= 16'd100;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LED_COUNT:      r_cfg.led_count      <= i_cfg_data[6:0];
                CFG_DISPLAY_MODE:   r_cfg.display_mode   <= i_cfg_data[1:0];
                CFG_GREEN_THRESH:   r_cfg.green_thresh   <= i_cfg_data[10:0];
                CFG_YELLOW_THRESH:  r_cfg.yellow_thresh  <= i_cfg_data[10:0];
                CFG_RED_THRESH:     r_cfg.red_thresh     <= i_cfg_data[10:0];
                CFG_BLINK_THRESH:   r_cfg.blink_thresh   <= i_cfg_data[10:0];
                CFG_BLINK_INTERVAL: r_cfg.blink_interval <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rsl_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_rpm_level  (i_rpm_level),
        .i_now_ms     (i_now_ms),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_frame      (push_frame)
    );

    rsl_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_frame (push_frame),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_frame  (pop_frame)
    );

    rsl_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame_valid (pop_valid),
        .o_frame_ready (pop_ready),
        .i_frame       (pop_frame),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pixel_index (o_pixel_index),
        .o_red_level   (o_red_level),
        .o_green_level (o_green_level),
        .o_blue_level  (o_blue_level),
        .o_frame_last  (o_frame_last)
    );

endmodule

@@ rtl/rsl_checker.sv @@
// rpm shift-light bar port checker: frame sequencing and output handshake
// checks, bound to rpm_shift_light_bar; no package needed
`timescale 1ns / 1ps

module rsl_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [5:0] o_pixel_index,
    input logic       o_frame_last
);

    // a stalled pixel holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pixel_index)
                                      && $stable(o_frame_last))
        else $error("output pixel changed while stalled");

    // within a frame the next pixel follows at once with the next index
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_frame_last |=>
            o_out_valid && (o_pixel_index == $past(o_pixel_index) + 6'd1))
        else $error("pixel index did not advance within frame");

    // a frame that opens after a gap in valid starts at led 0
    a_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !$past(o_out_valid) |-> o_pixel_index == 6'd0)
        else $error("frame did not start at pixel 0");

    // nothing left over after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind rpm_shift_light_bar rsl_checker u_rsl_checker (.*);

@@ tb/tb_top.sv @@
// self-checking testbench for rpm_shift_light_bar: a directed table, then random
// readings under three idling patterns, checked pixel by pixel against a predictor
// depends on rsl_pkg and the rpm_shift_light_bar rtl
`timescale 1ns / 1ps

module tb_top;
    import rsl_pkg::*;

    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          DRAIN_CYCLES  = 4;
    localparam int          TAIL_CYCLES   = 80;
    localparam int          END_WAIT      = 100000;
    localparam int          DEFAULT_LEDS  = 8;
    localparam int          RANDOM_ROUNDS = 29;
    localparam logic [1:0]  MODE_SPARE    = 2'd3;

    typedef struct packed {
        logic [5:0] pix_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } t_pixel;

    // one row of the directed table: a register write or a reading
    typedef struct packed {
        logic        is_cfg;
        logic [2:0]  reg_idx;
        logic [15:0] reg_data;
        logic [10:0] rpm;
        logic [31:0] now;
        logic        typed;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [6:0]  lit;
    } t_step;

    localparam int NUM_ROWS = 34;

    // typed rows run with the reset settings: bar mode, eight leds
    localparam t_step DIRECTED [NUM_ROWS] = '{
        '{1'b0, '0, '0, 11'd0,    32'd0,          1'b1, 8'd0,   8'd0,   8'd255, 7'd0},
        '{1'b0, '0, '0, 11'd1,    32'd5,          1'b1, 8'd0,   8'd0,   8'd255, 7'd1},
        '{1'b0, '0, '0, 11'd129,  32'd11,         1'b1, 8'd0,   8'd0,   8'd255, 7'd2},
        '{1'b0, '0, '0, 11'd511,  32'd12,         1'b1, 8'd0,   8'd0,   8'd255, 7'd4},
        '{1'b0, '0, '0, 11'd512,  32'd13,         1'b1, 8'd0,   8'd255, 8'd0,   7'd4},
        '{1'b0, '0, '0, 11'd768,  32'd15,         1'b1, 8'd255, 8'd180, 8'd0,   7'd6},
        '{1'b0, '0, '0, 11'd922,  32'd17,         1'b1, 8'd255, 8'd0,   8'd0,   7'd8},
        '{1'b0, '0, '0, 11'd972,  32'd18,         1'b1, 8'd255, 8'd0,   8'd0,   7'd8},
        '{1'b0, '0, '0, 11'd973,  32'd100,        1'b1, 8'd255, 8'd0,   8'd0,   7'd8},
        '{1'b0, '0, '0, 11'd2047, 32'd118,        1'b1, 8'd255, 8'd0,   8'd0,   7'd0},
        '{1'b0, '0, '0, 11'd1500, 32'd218,        1'b1, 8'd255, 8'd0,   8'd0,   7'd8},
        '{1'b0, '0, '0, 11'd500,  32'hffff_ffc0,  1'b1, 8'd0,   8'd0,   8'd255, 7'd4},
        '{1'b0, '0, '0, 11'd1024, 32'h0000_0020,  1'b1, 8'd255, 8'd0,   8'd0,   7'd8},
        '{1'b0, '0, '0, 11'd1024, 32'h0000_0024,  1'b1, 8'd255, 8'd0,   8'd0,   7'd0},
        '{1'b0, '0, '0, 11'd1024, 32'hffff_ffff,  1'b1, 8'd255, 8'd0,   8'd0,   7'd8},
        '{1'b0, '0, '0, 11'd1024, 32'h0000_0063,  1'b1, 8'd255, 8'd0,   8'd0,   7'd0},
        '{1'b1, CFG_DISPLAY_MODE, 16'(MODE_SOLID), '0, '0, 1'b0, '0, '0, '0, '0},
        '{1'b0, '0, '0, 11'd0,    32'h0000_1000,  1'b0, '0, '0, '0, '0},
        '{1'b0, '0, '0, 11'd1024, 32'h0000_1010,  1'b0, '0, '0, '0, '0},
        '{1'b1, CFG_DISPLAY_MODE, 16'(MODE_CENTRE), '0, '0, 1'b0, '0, '0, '0, '0},
        '{1'b0, '0, '0, 11'd300,  32'h0000_2000,  1'b0, '0, '0, '0, '0},
        '{1'b1, CFG_LED_COUNT, 16'd0, '0, '0, 1'b0, '0, '0, '0, '0},
        '{1'b0, '0, '0, 11'd700,  32'h0000_2100,  1'b0, '0, '0, '0, '0},
        '{1'b1, CFG_LED_COUNT, 16'd127, '0, '0, 1'b0, '0, '0, '0, '0},
        '{1'b1, CFG_DISPLAY_MODE, 16'(MODE_SPARE), '0, '0, 1'b0, '0, '0, '0, '0},
        '{1'b0, '0, '0, 11'd1024, 32'h0000_2110,  1'b0, '0, '0, '0, '0},
        '{1'b1, CFG_BLINK_INTERVAL, 16'd0, '0, '0, 1'b0, '0, '0, '0, '0},
        '{1'b0, '0, '0, 11'd1024, 32'h0000_2111,  1'b0, '0, '0, '0, '0},
        '{1'b0, '0, '0, 11'd1024, 32'h0000_2111,  1'b0, '0, '0, '0, '0},
        '{1'b1, CFG_GREEN_THRESH, 16'd2047, '0, '0, 1'b0, '0, '0, '0, '0},
        '{1'b1, CFG_YELLOW_THRESH, 16'd2047, '0, '0, 1'b0, '0, '0, '0, '0},
        '{1'b1, CFG_RED_THRESH, 16'd2047, '0, '0, 1'b0, '0, '0, '0, '0},
        '{1'b1, CFG_BLINK_THRESH, 16'd2047, '0, '0, 1'b0, '0, '0, '0, '0},
        '{1'b0, '0, '0, 11'd2047, 32'h0000_3000,  1'b0, '0, '0, '0, '0}
    };

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic [2:0]  i_cfg_index   = '0;
    logic [15:0] i_cfg_data    = '0;
    logic        i_in_valid    = 1'b0;
    logic [10:0] i_rpm_level   = '0;
    logic [31:0] i_now_ms      = '0;
    logic        i_out_ready   = 1'b0;
    logic        o_cfg_ready;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [5:0]  o_pixel_index;
    logic [7:0]  o_red_level;
    logic [7:0]  o_green_level;
    logic [7:0]  o_blue_level;
    logic        o_frame_last;

    // predictor state and register shadow
    t_cfg        cfg_shadow   = '{7'd8, MODE_BAR, 11'd512, 11'd768, 11'd922, 11'd973, 16'd100};
    logic        blink_lit    = 1'b1;
    logic [31:0] toggle_stamp = '0;

    t_pixel      pending_pixels[$];
    int          error_count   = 0;
    int          cycle_count   = 0;
    int          send_idle_pct = 16;
    int          recv_idle_pct = 50;

    rpm_shift_light_bar u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_rpm_level   (i_rpm_level),
        .i_now_ms      (i_now_ms),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pixel_index (o_pixel_index),
        .o_red_level   (o_red_level),
        .o_green_level (o_green_level),
        .o_blue_level  (o_blue_level),
        .o_frame_last  (o_frame_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_error(input string msg);
        if (error_count < 100) $display("cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want, input logic [5:0] pix);
        if (got !== want)
            report_error($sformatf("pixel %0d %s is %0d, expected %0d", pix, name, got, want));
    endtask

    // works out the frame for one reading and advances the blink state
    task automatic predict_frame(input logic [10:0] rpm, input logic [31:0] now,
                                 input bit record);
        int unsigned lvl, cnt, lit, first, stop, scale, r, g, b;
        logic [31:0] elapsed;
        lvl = (rpm > FULL_SCALE) ? 1024 : rpm;
        cnt = cfg_shadow.led_count;
        if (cnt < 1) cnt = 1;
        if (cnt > MAX_LEDS) cnt = MAX_LEDS;

        if (lvl >= cfg_shadow.red_thresh) begin
            r = 255; g = 0; b = 0;
        end else if (lvl >= cfg_shadow.yellow_thresh) begin
            r = 255; g = 180; b = 0;
        end else if (lvl >= cfg_shadow.green_thresh) begin
            r = 0; g = 255; b = 0;
        end else begin
            r = 0; g = 0; b = 255;
        end

        if (lvl >= cfg_shadow.blink_thresh) begin
            elapsed = now - toggle_stamp;
            if (elapsed >= {16'd0, cfg_shadow.blink_interval}) begin
                toggle_stamp = now;
                blink_lit    = !blink_lit;
            end
        end else begin
            blink_lit    = 1'b1;
            toggle_stamp = now;
        end

        first = 0;
        stop  = 0;
        if (blink_lit) begin
            if (cfg_shadow.display_mode == MODE_SOLID) begin
                scale = 102 + ((922 * lvl) >> 10);
                r     = (r * scale) >> 10;
                g     = (g * scale) >> 10;
                b     = (b * scale) >> 10;
                stop  = cnt;
            end else begin
                lit = (lvl * cnt + 1023) >> 10;
                if (lit > cnt) lit = cnt;
                if (cfg_shadow.display_mode == MODE_CENTRE) first = (cnt - lit) / 2;
                stop = first + lit;
            end
        end

        if (!record) return;
        for (int i = 0; i < cnt; i++) begin
            if (i >= first && i < stop)
                pending_pixels.push_back('{6'(i), 8'(r), 8'(g), 8'(b), i + 1 == cnt});
            else
                pending_pixels.push_back('{6'(i), 8'd0, 8'd0, 8'd0, i + 1 == cnt});
        end
    endtask

    task automatic send_reading(input logic [10:0] rpm, input logic [31:0] now);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid  <= 1'b1;
        i_rpm_level <= rpm;
        i_now_ms    <= now;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // leaves valid high; the caller lowers it after the last write of a batch
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_LED_COUNT:      cfg_shadow.led_count      = data[6:0];
            CFG_DISPLAY_MODE:   cfg_shadow.display_mode   = data[1:0];
            CFG_GREEN_THRESH:   cfg_shadow.green_thresh   = data[10:0];
            CFG_YELLOW_THRESH:  cfg_shadow.yellow_thresh  = data[10:0];
            CFG_RED_THRESH:     cfg_shadow.red_thresh     = data[10:0];
            CFG_BLINK_THRESH:   cfg_shadow.blink_thresh   = data[10:0];
            CFG_BLINK_INTERVAL: cfg_shadow.blink_interval = data;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic randomise_settings();
        logic [6:0]  count;
        logic [10:0] grn, yel, red, blk;
        logic [15:0] interval;
        case ($urandom_range(9))
            0:       count = 7'd0;
            1:       count = 7'd127;
            2:       count = 7'd64;
            3:       count = 7'($urandom_range(127, 65));
            default: count = 7'($urandom_range(16, 1));
        endcase
        // mostly ordered thresholds, now and then any order and beyond full scale
        if ($urandom_range(5) == 0) begin
            grn = 11'($urandom);
            yel = 11'($urandom);
            red = 11'($urandom);
        end else begin
            grn = 11'($urandom_range(1024, 0));
            yel = 11'($urandom_range(1024, grn));
            red = 11'($urandom_range(1024, yel));
        end
        case ($urandom_range(7))
            0:       blk = 11'($urandom_range(2047, 1025));
            1:       blk = 11'd0;
            default: blk = 11'($urandom_range(1024, 700));
        endcase
        case ($urandom_range(7))
            0:       interval = 16'd0;
            1:       interval = 16'hffff;
            2:       interval = 16'($urandom);
            default: interval = 16'($urandom_range(200, 1));
        endcase
        wait_drained();
        write_reg(CFG_LED_COUNT, 16'(count));
        write_reg(CFG_DISPLAY_MODE, 16'($urandom_range(3)));
        write_reg(CFG_GREEN_THRESH, 16'(grn));
        write_reg(CFG_YELLOW_THRESH, 16'(yel));
        write_reg(CFG_RED_THRESH, 16'(red));
        write_reg(CFG_BLINK_THRESH, 16'(blk));
        write_reg(CFG_BLINK_INTERVAL, interval);
        i_cfg_valid <= 1'b0;
    endtask

    // pixel checker; ready is drawn after the transaction of this edge is judged
    always @(posedge i_clk) begin : pixel_checker
        t_pixel want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_pixels.size() == 0) begin
                report_error($sformatf("pixel %0d arrived with nothing expected",
                                       o_pixel_index));
            end else begin
                want = pending_pixels.pop_front();
                check_field("pixel_index", 8'(o_pixel_index), 8'(want.pix_index),
                            want.pix_index);
                check_field("red_level", o_red_level, want.red, want.pix_index);
                check_field("green_level", o_green_level, want.green, want.pix_index);
                check_field("blue_level", o_blue_level, want.blue, want.pix_index);
                check_field("frame_last", 8'(o_frame_last), 8'(want.last), want.pix_index);
            end
        end
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_top failed");
        $finish;
    end

    initial begin
        t_step       row;
        logic [10:0] rpm;
        logic [31:0] clock_ms;
        int          near, lo, wait_cycles;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < NUM_ROWS; k++) begin
            row = DIRECTED[k];
            if (row.is_cfg) begin
                if (!DIRECTED[k - 1].is_cfg) wait_drained();
                write_reg(row.reg_idx, row.reg_data);
            end else begin
                i_cfg_valid <= 1'b0;
                send_reading(row.rpm, row.now);
                predict_frame(row.rpm, row.now, !row.typed);
                if (row.typed) begin
                    for (int i = 0; i < DEFAULT_LEDS; i++) begin
                        if (i < row.lit)
                            pending_pixels.push_back('{6'(i), row.r, row.g, row.b,
                                                       i == DEFAULT_LEDS - 1});
                        else
                            pending_pixels.push_back('{6'(i), 8'd0, 8'd0, 8'd0,
                                                       i == DEFAULT_LEDS - 1});
                    end
                end
            end
        end

        clock_ms = $urandom;
        for (int phase = 0; phase < 3; phase++) begin
            for (int half = 0; half < 2; half++) begin
                randomise_settings();
                send_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 50 : 0;
                recv_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 16 : 0;
                for (int n = 0; n < RANDOM_ROUNDS; n++) begin
                    // hold the sender off until the display has caught up
                    if (half == 1 && n == RANDOM_ROUNDS / 3) wait_drained();
                    case ($urandom_range(15))
                        0:       clock_ms = $urandom;
                        1:       ;
                        default: clock_ms = clock_ms + $urandom_range(
                                     2 * cfg_shadow.blink_interval + 2, 0);
                    endcase
                    case ($urandom_range(9))
                        0, 1, 2: rpm = 11'($urandom);
                        3, 4, 5: begin
                            lo  = (cfg_shadow.blink_thresh > 1024) ? 1024
                                                                   : cfg_shadow.blink_thresh;
                            rpm = 11'($urandom_range(1024, lo));
                        end
                        6, 7: begin
                            case ($urandom_range(3))
                                0:       near = cfg_shadow.green_thresh;
                                1:       near = cfg_shadow.yellow_thresh;
                                2:       near = cfg_shadow.red_thresh;
                                default: near = cfg_shadow.blink_thresh;
                            endcase
                            near = near + int'($urandom_range(4)) - 2;
                            if (near < 0) near = 0;
                            rpm = 11'(near);
                        end
                        default: rpm = 11'($urandom_range(1024, 0));
                    endcase
                    send_reading(rpm, clock_ms);
                    predict_frame(rpm, clock_ms, 1'b1);
                end
            end
        end

        i_in_valid <= 1'b0;
        for (wait_cycles = 0; wait_cycles < END_WAIT && pending_pixels.size() != 0;
             wait_cycles++)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_pixels.size() != 0)
            report_error($sformatf("%0d expected pixels never arrived",
                                   pending_pixels.size()));

        if (error_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
